// ===== hdl/m4inv_pkg.sv =====
// m4inv_pkg: shared types and constant tables for matrix4_cofactor_inverse.
// Holds the sequencer state enum and the cofactor/pair index tables.
// No dependencies.
package m4inv_pkg;

  // Accumulator width: six 96-bit products, exact, plus rounding headroom.
  localparam int ACC_W = 100;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PAIR_A,
    S_PAIR_MUL,
    S_PAIR_WR,
    S_COF_MUL,
    S_COF_ACC,
    S_COF_FIN,
    S_DET_MUL,
    S_DET_ACC,
    S_DET_FIN,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_FIN,
    S_OUT
  } state_t;

  // Upper-half pair products; lower half uses the same indices minus 8.
  localparam logic [3:0] PAIR_A [12] = '{4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10,
                                         4'd8, 4'd11, 4'd8, 4'd10, 4'd8, 4'd9};
  localparam logic [3:0] PAIR_B [12] = '{4'd15, 4'd14, 4'd15, 4'd13, 4'd14, 4'd13,
                                         4'd15, 4'd12, 4'd14, 4'd12, 4'd13, 4'd12};

  // Per cofactor: pair index and element index of each term.
  // Terms 0..2 are added, terms 3..5 subtracted.
  localparam logic [3:0] COF_PAIR [16][6] = '{
    '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd5},
    '{4'd1, 4'd6, 4'd9, 4'd0, 4'd7, 4'd8},
    '{4'd2, 4'd7, 4'd10, 4'd3, 4'd6, 4'd11},
    '{4'd5, 4'd8, 4'd11, 4'd4, 4'd9, 4'd10},
    '{4'd1, 4'd2, 4'd5, 4'd0, 4'd3, 4'd4},
    '{4'd0, 4'd7, 4'd8, 4'd1, 4'd6, 4'd9},
    '{4'd3, 4'd6, 4'd11, 4'd2, 4'd7, 4'd10},
    '{4'd4, 4'd9, 4'd10, 4'd5, 4'd8, 4'd11},
    '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd5},
    '{4'd1, 4'd6, 4'd9, 4'd0, 4'd7, 4'd8},
    '{4'd2, 4'd7, 4'd10, 4'd3, 4'd6, 4'd11},
    '{4'd5, 4'd8, 4'd11, 4'd4, 4'd9, 4'd10},
    '{4'd2, 4'd5, 4'd1, 4'd4, 4'd0, 4'd3},
    '{4'd8, 4'd0, 4'd7, 4'd6, 4'd9, 4'd1},
    '{4'd6, 4'd11, 4'd3, 4'd10, 4'd2, 4'd7},
    '{4'd10, 4'd4, 4'd9, 4'd8, 4'd11, 4'd5}
  };
  localparam logic [3:0] COF_ELEM [16][6] = '{
    '{4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7},
    '{4'd4, 4'd6, 4'd7, 4'd4, 4'd6, 4'd7},
    '{4'd4, 4'd5, 4'd7, 4'd4, 4'd5, 4'd7},
    '{4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6},
    '{4'd1, 4'd2, 4'd3, 4'd1, 4'd2, 4'd3},
    '{4'd0, 4'd2, 4'd3, 4'd0, 4'd2, 4'd3},
    '{4'd0, 4'd1, 4'd3, 4'd0, 4'd1, 4'd3},
    '{4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2},
    '{4'd13, 4'd14, 4'd15, 4'd13, 4'd14, 4'd15},
    '{4'd12, 4'd14, 4'd15, 4'd12, 4'd14, 4'd15},
    '{4'd12, 4'd13, 4'd15, 4'd12, 4'd13, 4'd15},
    '{4'd12, 4'd13, 4'd14, 4'd12, 4'd13, 4'd14},
    '{4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10},
    '{4'd11, 4'd8, 4'd10, 4'd10, 4'd11, 4'd8},
    '{4'd9, 4'd11, 4'd8, 4'd11, 4'd8, 4'd9},
    '{4'd10, 4'd8, 4'd9, 4'd9, 4'd10, 4'd8}
  };

endpackage

// ===== hdl/matrix4_cofactor_inverse.sv =====
// matrix4_cofactor_inverse: 4x4 fixed-point matrix inverse by cofactors.
// One shared 33x33 signed multiplier and a restoring divider under a sequencer.
// Depends on m4inv_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): 16 words, one matrix element each,
//    row-major, signed Q(32-F).F. in_stall is low only while loading.
//  - Output channel (out_valid / out_stall): 16 words of the inverse,
//    row-major, with singular, saturated and last_element (on word 16).
//  - After the 16th input word the block computes: 24 pair products,
//    16 cofactors (12 multiply/accumulate halves plus a finish each), the
//    determinant (4 cofactors in two halves each, plus a finish), then per
//    output word one serial divide; the serial divider dominates.
//  - Singular matrix (rounded determinant zero): all 16 words are zero with
//    singular set, and no divide is run.
//  - A stalled output word holds its value; the sequencer waits on it.
//  - Reset (rst_n low, synchronous) returns to loading with the element
//    count cleared; no output word is pending.
//  - Loading of the next matrix starts only after the last word is taken.
module matrix4_cofactor_inverse #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_element_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_inverse_value,
  output logic               out_singular,
  output logic               out_saturated,
  output logic               out_last_element
);
  import m4inv_pkg::*;

  localparam int NUM_W = 64 + FRACTION_BITS;   // divide numerator width
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W:0] Q_POS_MAX = (NUM_W + 1)'(64'h7FFF_FFFF);
  localparam logic [NUM_W:0] Q_NEG_MAX = (NUM_W + 1)'(64'h8000_0000);

  // Sequencer
  state_t state_r, state_nxt;

  // Storage
  logic signed [31:0] elem_r [16];
  logic [4:0]         load_cnt_r;
  logic signed [63:0] pr_r [24];
  logic signed [63:0] cof_r [16];
  logic [15:0]        cclip_r;
  logic signed [63:0] det_r;
  logic               dclip_r;

  // Counters
  logic [4:0] idx_r;    // pair index, then cofactor / output index
  logic [2:0] term_r;
  logic       part_r;   // 0: low 32 bits of the wide operand, 1: high

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] opa_r;
  logic signed [65:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, addend;

  // Divider
  logic [NUM_W-1:0] num_r, quo_r;
  logic [63:0]      rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [64:0]      rem_sh;
  logic             rem_ge;

  // Rounding / saturation of the accumulator
  logic signed [ACC_W-1:0] acc_rnd, acc_sh;
  logic                    acc_fit;
  logic signed [63:0]      acc_sat;

  // Table lookups
  logic [3:0] tidx, pa_idx, pb_idx, cof_p, cof_e;
  logic [4:0] pidx;
  logic [3:0] kidx;

  function automatic logic [3:0] tr(input logic [3:0] k);
    return {k[1:0], k[3:2]};   // transposed element index
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  assign kidx   = idx_r[3:0];
  assign tidx   = (idx_r < 5'd12) ? idx_r[3:0] : 4'(idx_r - 5'd12);
  assign pa_idx = (idx_r < 5'd12) ? PAIR_A[tidx] : 4'(PAIR_A[tidx] - 4'd8);
  assign pb_idx = (idx_r < 5'd12) ? PAIR_B[tidx] : 4'(PAIR_B[tidx] - 4'd8);
  assign cof_p  = COF_PAIR[kidx][term_r];
  assign cof_e  = COF_ELEM[kidx][term_r];
  assign pidx   = kidx[3] ? 5'(cof_p) + 5'd12 : 5'(cof_p);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PAIR_MUL: begin
        mul_a = 33'(opa_r);
        mul_b = 33'(elem_r[tr(pb_idx)]);
      end
      S_COF_MUL: begin
        mul_a = part_r ? 33'(signed'(pr_r[pidx][63:32])) : {1'b0, pr_r[pidx][31:0]};
        mul_b = 33'(elem_r[tr(cof_e)]);
      end
      S_DET_MUL: begin
        mul_a = part_r ? 33'(signed'(cof_r[kidx][63:32])) : {1'b0, cof_r[kidx][31:0]};
        mul_b = 33'(elem_r[tr(kidx)]);
      end
      default: ;
    endcase
  end

  assign addend = part_r ? (ACC_W'(prod_r) <<< 32) : ACC_W'(prod_r);

  // Round half up and shift: 2F for cofactors, F for the determinant
  always_comb begin
    if (state_r == S_COF_FIN) begin
      acc_rnd = acc_r + (ACC_W'(1) <<< (2 * FRACTION_BITS - 1));
      acc_sh  = acc_rnd >>> (2 * FRACTION_BITS);
    end else begin
      acc_rnd = acc_r + (ACC_W'(1) <<< (FRACTION_BITS - 1));
      acc_sh  = acc_rnd >>> FRACTION_BITS;
    end
    acc_fit = (&acc_sh[ACC_W-1:63]) || !(|acc_sh[ACC_W-1:63]);
    if (acc_fit)
      acc_sat = acc_sh[63:0];
    else
      acc_sat = acc_sh[ACC_W-1] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
  end

  // Divider step
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  // Final rounding and saturation of one quotient
  logic [NUM_W:0]     quo_rnd;
  logic               q_neg, q_clip;
  logic signed [31:0] q_val;
  always_comb begin
    quo_rnd = {1'b0, quo_r} + (NUM_W + 1)'({rem_r, 1'b0} >= {1'b0, dvs_r});
    q_neg   = cof_r[kidx][63] ^ det_r[63];
    q_clip  = 1'b0;
    if (q_neg) begin
      if (quo_rnd > Q_NEG_MAX) begin
        q_val  = 32'sh8000_0000;
        q_clip = 1'b1;
      end else begin
        q_val = 32'(-quo_rnd[31:0]);
      end
    end else begin
      if (quo_rnd > Q_POS_MAX) begin
        q_val  = 32'sh7FFF_FFFF;
        q_clip = 1'b1;
      end else begin
        q_val = signed'(quo_rnd[31:0]);
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid && load_cnt_r == 5'd15) state_nxt = S_PAIR_A;
      end
      S_PAIR_A:   state_nxt = S_PAIR_MUL;
      S_PAIR_MUL: state_nxt = S_PAIR_WR;
      S_PAIR_WR:  state_nxt = (idx_r == 5'd23) ? S_COF_MUL : S_PAIR_A;
      S_COF_MUL:  state_nxt = S_COF_ACC;
      S_COF_ACC:  state_nxt = (part_r && term_r == 3'd5) ? S_COF_FIN : S_COF_MUL;
      S_COF_FIN:  state_nxt = (idx_r == 5'd15) ? S_DET_MUL : S_COF_MUL;
      S_DET_MUL:  state_nxt = S_DET_ACC;
      S_DET_ACC:  state_nxt = (part_r && idx_r == 5'd3) ? S_DET_FIN : S_DET_MUL;
      S_DET_FIN:  state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = (det_r == '0) ? S_OUT : S_DIV_STEP;
      S_DIV_STEP: state_nxt = (cnt_r == CNT_W'(1)) ? S_DIV_FIN : S_DIV_STEP;
      S_DIV_FIN:  state_nxt = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = (idx_r == 5'd15) ? S_LOAD : S_DIV_INIT;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Load counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else if (state_r == S_LOAD && in_valid) begin
      load_cnt_r <= (load_cnt_r == 5'd15) ? 5'd0 : load_cnt_r + 5'd1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) elem_r[load_cnt_r[3:0]] <= in_element_value;
        idx_r <= '0;
      end
      S_PAIR_A: opa_r <= elem_r[tr(pa_idx)];
      S_PAIR_MUL: prod_r <= mul_a * mul_b;
      S_PAIR_WR: begin
        pr_r[idx_r] <= prod_r[63:0];
        idx_r       <= (idx_r == 5'd23) ? 5'd0 : idx_r + 5'd1;
        term_r      <= '0;
        part_r      <= 1'b0;
        acc_r       <= '0;
      end
      S_COF_MUL: prod_r <= mul_a * mul_b;
      S_COF_ACC: begin
        acc_r  <= (term_r < 3'd3) ? acc_r + addend : acc_r - addend;
        part_r <= !part_r;
        if (part_r) term_r <= term_r + 3'd1;
      end
      S_COF_FIN: begin
        cof_r[kidx]   <= acc_sat;
        cclip_r[kidx] <= !acc_fit;
        acc_r         <= '0;
        term_r        <= '0;
        part_r        <= 1'b0;
        idx_r         <= (idx_r == 5'd15) ? 5'd0 : idx_r + 5'd1;
      end
      S_DET_MUL: prod_r <= mul_a * mul_b;
      S_DET_ACC: begin
        acc_r  <= acc_r + addend;
        part_r <= !part_r;
        if (part_r) idx_r <= idx_r + 5'd1;
      end
      S_DET_FIN: begin
        det_r   <= acc_sat;
        dclip_r <= !acc_fit;
        idx_r   <= '0;
      end
      S_DIV_INIT: begin
        num_r <= {mag(cof_r[kidx]), FRACTION_BITS'(0)};
        dvs_r <= mag(det_r);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CNT_W'(NUM_W);
        out_last_element <= (idx_r == 5'd15);
        if (det_r == '0) begin
          out_inverse_value <= '0;
          out_singular      <= 1'b1;
          out_saturated     <= 1'b0;
        end
      end
      S_DIV_STEP: begin
        rem_r <= rem_ge ? 64'(rem_sh - {1'b0, dvs_r}) : rem_sh[63:0];
        quo_r <= {quo_r[NUM_W-2:0], rem_ge};
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_DIV_FIN: begin
        out_inverse_value <= q_val;
        out_singular      <= 1'b0;
        out_saturated     <= q_clip || cclip_r[kidx] || dclip_r;
      end
      S_OUT: begin
        if (!out_stall && idx_r != 5'd15) idx_r <= idx_r + 5'd1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // No element is taken while a result word is on offer.
  a_no_load_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while output pending");

  // A singular word carries zero and no saturation.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inverse_value == 32'sd0 && !out_saturated))
    else $error("singular word not zero");

  // Taking the last word reopens the input.
  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_element) |=> !in_stall)
    else $error("input not reopened after last word");
`endif

endmodule

// ===== tb/matrix4_cofactor_inverse_tb.sv =====
// matrix4_cofactor_inverse_tb: self-checking testbench for the 4x4 cofactor inverse.
// Feeds whole matrices as element words and predicts the inverse in Q16.16.
// Depends on hdl/matrix4_cofactor_inverse.sv (and its package).
module matrix4_cofactor_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int MATRICES = 18;               // 288 element words
  localparam int HOLDOFF_CYCLES = 3000;       // longer than one whole computation

  // Matrix flavors the generator knows about.
  typedef enum int {
    MK_IDENTITY, MK_ZERO, MK_WELL, MK_RANDOM, MK_DUP_ROW, MK_EXTREME,
    MK_TINY, MK_NEAR_SING
  } mkind_t;

  typedef struct {
    logic signed [31:0] value;
    logic               pause;   // wait for all inverse words before offering
  } element_word_t;

  typedef struct {
    logic signed [31:0] value;
    logic               singular;
    logic               saturated;
    logic               last;
  } inverse_word_t;

  // Upper-half pair products (transposed indices); lower half is the same minus 8.
  localparam int PAIR_HI [12] = '{10, 11, 9, 11, 9, 10, 8, 11, 8, 10, 8, 9};
  localparam int PAIR_LO [12] = '{15, 14, 15, 13, 14, 13, 15, 12, 14, 12, 13, 12};
  // Per cofactor: (pair, element) x 6, first three added, last three subtracted.
  localparam int COF_TERMS [16][12] = '{
    '{0,5, 3,6, 4,7,    1,5, 2,6, 5,7},
    '{1,4, 6,6, 9,7,    0,4, 7,6, 8,7},
    '{2,4, 7,5, 10,7,   3,4, 6,5, 11,7},
    '{5,4, 8,5, 11,6,   4,4, 9,5, 10,6},
    '{1,1, 2,2, 5,3,    0,1, 3,2, 4,3},
    '{0,0, 7,2, 8,3,    1,0, 6,2, 9,3},
    '{3,0, 6,1, 11,3,   2,0, 7,1, 10,3},
    '{4,0, 9,1, 10,2,   5,0, 8,1, 11,2},
    '{0,13, 3,14, 4,15, 1,13, 2,14, 5,15},
    '{1,12, 6,14, 9,15, 0,12, 7,14, 8,15},
    '{2,12, 7,13, 10,15, 3,12, 6,13, 11,15},
    '{5,12, 8,13, 11,14, 4,12, 9,13, 10,14},
    '{2,10, 5,11, 1,9,  4,11, 0,9, 3,10},
    '{8,11, 0,8, 7,10,  6,10, 9,11, 1,8},
    '{6,9, 11,11, 3,8,  10,11, 2,8, 7,9},
    '{10,10, 4,8, 9,9,  8,9, 11,10, 5,8}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_element_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_inverse_value;
  logic               out_singular;
  logic               out_saturated;
  logic               out_last_element;

  matrix4_cofactor_inverse #(.FRACTION_BITS(FRAC)) uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_element_value,
    .out_valid, .out_stall, .out_inverse_value,
    .out_singular, .out_saturated, .out_last_element
  );

  always #5 clk = ~clk;

  element_word_t      pending_q[$];     // words not yet offered
  inverse_word_t      inverse_q[$];     // predicted inverse words, oldest first
  logic signed [31:0] load_buf[16];     // predictor's copy of the loading matrix
  int                 load_cnt = 0;
  int                 words_sent = 0;
  int                 words_checked = 0;
  int                 singular_seen = 0;
  int                 sat_seen = 0;
  int                 errors = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp a wide signed value into signed 64 bits, raising the clip flag.
  function automatic logic signed [63:0] clamp64(input logic signed [127:0] v,
                                                 inout logic clip);
    logic signed [127:0] top, bot;
    top = 64'sh7FFF_FFFF_FFFF_FFFF;
    bot = -(128'sd1 <<< 63);
    if (v > top) begin
      clip = 1'b1;
      return top[63:0];
    end
    if (v < bot) begin
      clip = 1'b1;
      return bot[63:0];
    end
    return v[63:0];
  endfunction

  // Full inverse of load_buf; pushes sixteen expected words.
  task automatic predict_inverse();
    logic signed [63:0]  s[16];
    logic signed [63:0]  pr[24];
    logic signed [63:0]  cof[16];
    logic                cclip[16];
    logic signed [127:0] acc, pa, pb;
    logic signed [63:0]  det;
    logic                dclip, neg, clip;
    logic [127:0]        mg, dv, num, q, rem;
    inverse_word_t       w;
    int                  base;
    // work on the transpose, as the block does
    for (int k = 0; k < 16; k++) s[k] = load_buf[(k % 4) * 4 + k / 4];
    for (int t = 0; t < 12; t++) begin
      pr[t]      = s[PAIR_HI[t]] * s[PAIR_LO[t]];
      pr[t + 12] = s[PAIR_HI[t] - 8] * s[PAIR_LO[t] - 8];
    end
    for (int k = 0; k < 16; k++) begin
      acc  = '0;
      base = (k < 8) ? 0 : 12;
      for (int t = 0; t < 6; t++) begin
        pa = pr[base + COF_TERMS[k][2 * t]];
        pb = s[COF_TERMS[k][2 * t + 1]];
        if (t < 3) acc = acc + pa * pb;
        else acc = acc - pa * pb;
      end
      // Q.3F -> Q.F, halves round up
      acc = (acc + (128'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
      cclip[k] = 1'b0;
      cof[k] = clamp64(acc, cclip[k]);
    end
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      pa = s[k];
      pb = cof[k];
      acc = acc + pa * pb;
    end
    acc = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    dclip = 1'b0;
    det = clamp64(acc, dclip);

    for (int k = 0; k < 16; k++) begin
      w.last = (k == 15);
      if (det == 0) begin
        w.value = '0;
        w.singular = 1'b1;
        w.saturated = 1'b0;
      end else begin
        mg   = (cof[k] < 0) ? 128'(-cof[k]) : 128'(cof[k]);
        dv   = (det < 0) ? 128'(-det) : 128'(det);
        // the negations above wrap for the 64-bit minimum; fix the magnitude
        mg   = mg & {64'd0, {64{1'b1}}};
        dv   = dv & {64'd0, {64{1'b1}}};
        neg  = (cof[k] < 0) != (det < 0);
        clip = cclip[k] | dclip;
        num  = mg << FRAC;
        q    = num / dv;
        rem  = num % dv;
        if (rem >= dv - rem) q = q + 1;     // nearest, halves away from zero
        if (neg) begin
          if (q > 128'h8000_0000) begin
            w.value = 32'sh8000_0000;
            clip = 1'b1;
          end else begin
            w.value = -q[31:0];
          end
        end else begin
          if (q > 128'h7FFF_FFFF) begin
            w.value = 32'sh7FFF_FFFF;
            clip = 1'b1;
          end else begin
            w.value = q[31:0];
          end
        end
        w.singular = 1'b0;
        w.saturated = clip;
      end
      inverse_q.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  task automatic queue_matrix(input mkind_t kind, input logic pause);
    logic signed [31:0] m[16];
    element_word_t      e;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        MK_IDENTITY: m[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
        MK_ZERO:     m[i] = '0;
        MK_WELL: begin
          // large diagonal, small off-diagonal entries: ordinary, mostly invertible matrices
          if (i % 5 == 0) m[i] = $signed($urandom_range(1, 8) << FRAC);
          else m[i] = $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh8000;
          if (i % 5 == 0 && $urandom_range(0, 1)) m[i] = -m[i];
        end
        MK_RANDOM, MK_DUP_ROW, MK_NEAR_SING: m[i] = rand_word();
        MK_EXTREME: begin
          case ($urandom_range(0, 4))
            0: m[i] = 32'sh8000_0000;
            1: m[i] = 32'sh7FFF_FFFF;
            2: m[i] = '0;
            3: m[i] = 32'sh1;
            default: m[i] = -32'sh1;
          endcase
        end
        default: m[i] = $signed($urandom_range(0, 6)) - 32'sd3;   // tiny values
      endcase
    end
    // singular by a repeated row; near singular by one lsb off it
    if (kind == MK_DUP_ROW)
      for (int c = 0; c < 4; c++) m[12 + c] = m[c];
    if (kind == MK_NEAR_SING) begin
      for (int c = 0; c < 4; c++) m[c] = $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
      for (int c = 0; c < 4; c++) m[12 + c] = m[c];
      m[15] = m[15] + 32'sd1;
    end
    for (int i = 0; i < 16; i++) begin
      e.value = m[i];
      e.pause = pause && (i == 0);
      pending_q.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_element_value <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        load_buf[load_cnt] = in_element_value;
        load_cnt = load_cnt + 1;
        words_sent = words_sent + 1;
        if (load_cnt == 16) begin
          load_cnt = 0;
          predict_inverse();
        end
      end
      // payload may only change when not held by a stall
      if (!in_valid || !in_stall) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].pause && inverse_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_element_value <= pending_q[0].value;
          void'(pending_q.pop_front());
          burst_left = burst_left - 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: phased pattern plus one long hold-off after matrix three
  // ---------------------------------------------------------------------------
  int  phase_cnt = 0;
  int  stall_mode = 0;
  int  holdoff_left = 0;
  logic holdoff_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!holdoff_done && words_checked >= 3 * 16 + 2) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      phase_cnt = phase_cnt + 1;
      if (phase_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
      if (holdoff_left > 0) begin
        holdoff_left = holdoff_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= (phase_cnt % 3 == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: field-by-field compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    inverse_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected inverse word value=%0d", out_inverse_value);
        errors = errors + 1;
      end else begin
        e = inverse_q.pop_front();
        if (out_inverse_value !== e.value) begin
          $error("inverse_value: expected %0d, got %0d", e.value, out_inverse_value);
          errors = errors + 1;
        end
        if (out_singular !== e.singular) begin
          $error("singular: expected %0b, got %0b", e.singular, out_singular);
          errors = errors + 1;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated: expected %0b, got %0b", e.saturated, out_saturated);
          errors = errors + 1;
        end
        if (out_last_element !== e.last) begin
          $error("last_element: expected %0b, got %0b", e.last, out_last_element);
          errors = errors + 1;
        end
        if (e.singular) singular_seen = singular_seen + 1;
        if (e.saturated) sat_seen = sat_seen + 1;
      end
      words_checked = words_checked + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed matrices, random mix, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    mkind_t kinds[6];
    kinds = '{MK_WELL, MK_RANDOM, MK_DUP_ROW, MK_EXTREME, MK_TINY, MK_NEAR_SING};
    // directed: identity, all-zero (singular), then extreme values
    queue_matrix(MK_IDENTITY, 1'b0);
    queue_matrix(MK_ZERO, 1'b0);
    queue_matrix(MK_EXTREME, 1'b0);
    for (int n = 3; n < MATRICES; n++) begin
      // one of each listed flavor first, then a random mix leaning toward ordinary ones
      if (n < 9) queue_matrix(kinds[n - 3], n == 8);
      else if ($urandom_range(0, 2) == 0) queue_matrix(MK_WELL, 1'b0);
      else queue_matrix(kinds[$urandom_range(0, 5)], 1'b0);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && words_sent == MATRICES * 16 && inverse_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d matrices, %0d inverse words checked (%0d singular, %0d saturated).",
             MATRICES, words_checked, singular_seen, sat_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d words pending", inverse_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
